[hdl/sbed_pkg.sv]
// Shared types, constants and helper functions of the edge decoder and mixer.
`default_nettype none

package sbed_pkg;

  // Packet framing
  localparam int FRAME_LEN   = 12;
  localparam int FRAME_COUNT = 24;
  localparam int DATA_FRAMES = 22;
  localparam int CHAN_COUNT  = 16;
  localparam int CHAN_BITS   = 11;
  localparam int FIELD_BITS  = DATA_FRAMES * 8;

  // Masked frame must show the start bit alone
  localparam logic [11:0] FRAME_START = 12'h800;

  // Register reset values
  localparam logic [31:0] GAP_RESET  = 32'd2000;
  localparam logic [11:0] MASK_RESET = 12'd2051;

  // Bit rounding: bits = (elapsed + 5) / 10, done as a reciprocal multiply
  localparam logic [31:0] ROUND_LIMIT = 32'd5125;  // at or above: more bits than any packet
  localparam logic [19:0] ROUND_BIAS  = 20'd5;
  localparam logic [20:0] K_ROUND     = 21'd6554;
  localparam int          ROUND_SHIFT = 16;

  // Channel scaling: trunc(|d * 510| / 1639) as a reciprocal multiply
  localparam logic [20:0] K_SCALE     = 21'd1310241;
  localparam int          SCALE_SHIFT = 31;

  // Constant select of the shared multiplier
  typedef enum logic [0:0] {
    MUL_ROUND = 1'b0,
    MUL_SCALE = 1'b1
  } mul_sel_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_GAP  = 1'b0,
    REG_MASK = 1'b1
  } cfg_reg_t;

  // Check one stored row: row bit i is frame bit 11-i
  function automatic logic frame_ok(input logic [11:0] row, input logic [11:0] mask);
    logic [11:0] frame;
    for (int i = 0; i < FRAME_LEN; i++) begin
      frame[FRAME_LEN-1-i] = row[i];
    end
    return ((frame & mask) == FRAME_START);
  endfunction

endpackage

`default_nettype wire

[hdl/sbed_mul_unit.sv]
// Shared constant multiplier with a registered product.
`default_nettype none

module sbed_mul_unit (
  input  logic               clk,
  input  logic               en,
  input  sbed_pkg::mul_sel_t sel,
  input  logic [19:0]        op_a,
  output logic [40:0]        prod_r
);
  import sbed_pkg::*;

  logic [20:0] k;

  // Pick the reciprocal constant
  always_comb begin
    unique case (sel)
      MUL_ROUND: k = K_ROUND;
      MUL_SCALE: k = K_SCALE;
      default:   k = K_ROUND;
    endcase
  end

  // Register the product
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 41'(op_a) * 41'(k);
    end
  end

endmodule

`default_nettype wire

[hdl/sbed_row_store.sv]
// Packet bit store: one frame-wide row per entry, registered read.
`default_nettype none

module sbed_row_store #(
  parameter  int DEPTH = 25,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [sbed_pkg::FRAME_LEN-1:0] wr_data,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  output logic [sbed_pkg::FRAME_LEN-1:0] rd_data_r
);
  import sbed_pkg::*;

  logic [FRAME_LEN-1:0] mem [DEPTH];

  // Write one full row
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one row
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hdl/sbus_edge_decoder_mixer.sv]
// Top level: edge timing, bit store fill, packet decode, mixing and result output.
//
// Usage: each item on the in_ channel is one line edge (new level, 32-bit tick
// timestamp). in_ready is high only while the block is idle. An ordinary edge
// is rounded to a bit count that is clamped to the free store bits; the fill
// runs one 12-bit row a cycle through the row store. An edge whose gap reaches
// the gap register decodes the packet: a gap check, then a read and check of
// each of the 24 frames through the row store read port (a failing frame ends
// the decode), scaling and mixing through the shared multiplier, a compare, then,
// if the decoded set changed, 16 results on the out_ channel, one per cycle
// while out_ready is high. out_last marks channel 15. A stalled receiver holds
// the current result and the block stays busy until all 16 are taken.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once and
// are meant for idle periods. Reset (rst_n low, synchronous) empties the store
// through its fill count, zeroes the published set and the previous timestamp,
// and loads the register defaults (gap 2000, frame mask 2051).
`default_nettype none

module sbus_edge_decoder_mixer #(
  parameter int PACKET_BITS = 300
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_line_level,
  input  logic [31:0]       in_edge_time,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        out_channel_index,
  output logic [10:0]       out_channel_value,
  output logic signed [8:0] out_drive_left,
  output logic signed [8:0] out_drive_right,
  output logic              out_failsafe,
  output logic              out_last,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [31:0]       cfg_wdata
);
  import sbed_pkg::*;

  localparam int ROWS = (PACKET_BITS + FRAME_LEN - 1) / FRAME_LEN;
  localparam int AW   = $clog2(ROWS);
  localparam int RIW  = $clog2(ROWS + 1);
  localparam int PW   = $clog2(PACKET_BITS + 1);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_CHK   = 12'b0000_0000_0010,
    S_RND   = 12'b0000_0000_0100,
    S_FILL  = 12'b0000_0000_1000,
    S_DADDR = 12'b0000_0001_0000,
    S_DDATA = 12'b0000_0010_0000,
    S_MAG   = 12'b0000_0100_0000,
    S_MUL   = 12'b0000_1000_0000,
    S_TAKE  = 12'b0001_0000_0000,
    S_MIX   = 12'b0010_0000_0000,
    S_CMP   = 12'b0100_0000_0000,
    S_EMIT  = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0]           gap_r, prev_time_r, elapsed_r;
  logic [11:0]           mask_r;
  logic                  store_bit_r;
  logic [PW-1:0]         pos_r, run_r, remaining, round_run;
  logic [RIW-1:0]        row_idx_r;
  logic [3:0]            col_r, space, take;
  logic [11:0]           rowbuf_r, fill_bits, row_filled, rd_row, frame_row;
  logic                  row_full, frame_good;
  logic [4:0]            frame_r;
  logic [FIELD_BITS-1:0] field_r, pub_field_r;
  logic                  fs_r, pub_fs_r, ch_sel_r, neg_r;
  logic [19:0]           mag_r, mag_nxt, mul_op;
  mul_sel_t              mul_sel;
  logic                  mul_en;
  logic [40:0]           prod_r;
  logic [9:0]            round_bits, quot, quot_c;
  logic [10:0]           chan_v, abs_d;
  logic signed [11:0]    diff_d;
  logic signed [8:0]     s0_r, s1_r, scaled, left_r, right_r, left_c, right_c;
  logic signed [8:0]     pub_left_r, pub_right_r;
  logic signed [9:0]     sum, diff;
  logic                  changed;
  logic [3:0]            idx_r;
  logic                  accept_in, accept_out, store_wr, store_rd;

  assign accept_in  = in_valid && in_ready;
  assign accept_out = out_valid && out_ready;

  // Bits still free in the packet, and the rounded run clamped to them
  assign remaining  = PW'(PACKET_BITS) - pos_r;
  assign round_bits = prod_r[ROUND_SHIFT +: 10];
  assign round_run  = ({1'b0, round_bits} < 11'(remaining)) ? PW'(round_bits) : remaining;

  // Fill step: as many bits as fit in the current row
  assign space      = 4'(FRAME_LEN) - col_r;
  assign take       = (run_r < PW'(space)) ? run_r[3:0] : space;
  assign fill_bits  = ((12'd1 << take) - 12'd1) << col_r;
  assign row_filled = rowbuf_r | (store_bit_r ? fill_bits : 12'd0);
  assign row_full   = (col_r + take) == 4'(FRAME_LEN);
  assign store_wr   = (state_r == S_FILL) && row_full;
  assign store_rd   = (state_r == S_DADDR);

  // Rows past the fill count read as zero; the open row lives in rowbuf_r
  assign frame_row  = (8'(frame_r) < 8'(row_idx_r)) ? rd_row :
                      ((8'(frame_r) == 8'(row_idx_r)) ? rowbuf_r : 12'd0);
  assign frame_good = frame_ok(frame_row, mask_r);

  // Channel magnitude: |(v - 172) * 510| by shift and subtract
  assign chan_v  = ch_sel_r ? field_r[2*CHAN_BITS-1:CHAN_BITS] : field_r[CHAN_BITS-1:0];
  assign diff_d  = $signed({1'b0, chan_v}) - 12'sd172;
  assign abs_d   = diff_d[11] ? 11'(-diff_d) : diff_d[10:0];
  assign mag_nxt = (20'(abs_d) << 9) - (20'(abs_d) << 1);

  // Shared multiplier operand and constant
  assign mul_en  = (state_r == S_CHK) || (state_r == S_MUL);
  assign mul_sel = (state_r == S_CHK) ? MUL_ROUND : MUL_SCALE;
  assign mul_op  = (state_r == S_CHK) ? (20'(elapsed_r[12:0]) + ROUND_BIAS) : mag_r;

  // Scaled channel, clamped to -255..255
  assign quot   = prod_r[SCALE_SHIFT +: 10];
  assign quot_c = (quot > 10'd510) ? 10'd510 : quot;
  assign scaled = neg_r ? -9'sd255 : 9'($signed({2'b00, quot_c}) - 12'sd255);

  // Mix and clamp
  assign sum     = 10'(s0_r) + 10'(s1_r);
  assign diff    = 10'(s1_r) - 10'(s0_r);
  assign left_c  = (sum > 10'sd255) ? 9'sd255 : ((sum < -10'sd255) ? -9'sd255 : 9'(sum));
  assign right_c = (diff > 10'sd255) ? 9'sd255 :
                   ((diff < -10'sd255) ? -9'sd255 : 9'(diff));

  assign changed = (field_r != pub_field_r) || (left_r != pub_left_r) ||
                   (right_r != pub_right_r) || (fs_r != pub_fs_r);

  sbed_row_store #(.DEPTH(ROWS)) u_store (
    .clk       (clk),
    .wr_en     (store_wr),
    .wr_addr   (row_idx_r[AW-1:0]),
    .wr_data   (row_filled),
    .rd_en     (store_rd),
    .rd_addr   (AW'(frame_r)),
    .rd_data_r (rd_row)
  );

  sbed_mul_unit u_mul (
    .clk    (clk),
    .en     (mul_en),
    .sel    (mul_sel),
    .op_a   (mul_op),
    .prod_r (prod_r)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept_in) state_nxt = S_CHK;
      S_CHK: begin
        if (elapsed_r >= gap_r) begin
          state_nxt = S_DADDR;
        end else if (elapsed_r >= ROUND_LIMIT) begin
          state_nxt = (remaining == '0) ? S_IDLE : S_FILL;
        end else begin
          state_nxt = S_RND;
        end
      end
      S_RND:   state_nxt = (round_run == '0) ? S_IDLE : S_FILL;
      S_FILL:  if (run_r == PW'(take)) state_nxt = S_IDLE;
      S_DADDR: state_nxt = S_DDATA;
      S_DDATA: begin
        if (!frame_good) begin
          state_nxt = S_IDLE;
        end else if (frame_r == 5'(FRAME_COUNT - 1)) begin
          state_nxt = S_MAG;
        end else begin
          state_nxt = S_DADDR;
        end
      end
      S_MAG:   state_nxt = S_MUL;
      S_MUL:   state_nxt = S_TAKE;
      S_TAKE:  state_nxt = ch_sel_r ? S_MIX : S_MAG;
      S_MIX:   state_nxt = S_CMP;
      S_CMP:   state_nxt = changed ? S_EMIT : S_IDLE;
      S_EMIT:  if (accept_out && (idx_r == 4'(CHAN_COUNT - 1))) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and data registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gap_r       <= GAP_RESET;
      mask_r      <= MASK_RESET;
      prev_time_r <= '0;
      pos_r       <= '0;
      row_idx_r   <= '0;
      col_r       <= '0;
      rowbuf_r    <= '0;
      pub_field_r <= '0;
      pub_left_r  <= '0;
      pub_right_r <= '0;
      pub_fs_r    <= 1'b0;
      idx_r       <= '0;
      ch_sel_r    <= 1'b0;
      frame_r     <= '0;
    end else begin
      state_r <= state_nxt;

      // Register writes
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_GAP:  gap_r  <= cfg_wdata;
          REG_MASK: mask_r <= cfg_wdata[11:0];
          default:  gap_r  <= gap_r;
        endcase
      end

      // Take the edge
      if (accept_in) begin
        store_bit_r <= ~in_line_level;
        elapsed_r   <= in_edge_time - prev_time_r;
        prev_time_r <= in_edge_time;
      end

      unique case (state_r)
        S_CHK: begin
          frame_r <= '0;
          if ((elapsed_r < gap_r) && (elapsed_r >= ROUND_LIMIT)) begin
            run_r <= remaining;
          end
        end
        S_RND: run_r <= round_run;
        // Fill one row segment, flush the row when it is full
        S_FILL: begin
          run_r <= run_r - PW'(take);
          pos_r <= pos_r + PW'(take);
          if (row_full) begin
            rowbuf_r  <= '0;
            col_r     <= '0;
            row_idx_r <= row_idx_r + RIW'(1);
          end else begin
            rowbuf_r <= row_filled;
            col_r    <= col_r + take;
          end
        end
        // Check a frame, collect data bytes and the failsafe bits
        S_DDATA: begin
          if ((frame_r >= 5'd1) && (frame_r <= 5'(DATA_FRAMES))) begin
            field_r <= {~frame_row[8:1], field_r[FIELD_BITS-1:8]};
          end
          if (frame_r == 5'(FRAME_COUNT - 1)) begin
            fs_r <= ~(frame_row[3] & frame_row[4]);
          end
          frame_r  <= frame_r + 5'd1;
          ch_sel_r <= 1'b0;
          // Drop the packet once the store is read out or a frame fails
          if (!frame_good || (frame_r == 5'(FRAME_COUNT - 1))) begin
            pos_r     <= '0;
            row_idx_r <= '0;
            col_r     <= '0;
            rowbuf_r  <= '0;
          end
        end
        S_MAG: begin
          mag_r <= mag_nxt;
          neg_r <= diff_d[11];
        end
        S_TAKE: begin
          if (ch_sel_r) begin
            s1_r <= scaled;
          end else begin
            s0_r     <= scaled;
            ch_sel_r <= 1'b1;
          end
        end
        S_MIX: begin
          left_r  <= left_c;
          right_r <= right_c;
        end
        // Publish a changed set
        S_CMP: begin
          idx_r <= '0;
          if (changed) begin
            pub_field_r <= field_r;
            pub_left_r  <= left_r;
            pub_right_r <= right_r;
            pub_fs_r    <= fs_r;
          end
        end
        // Advance to the next channel
        S_EMIT: begin
          if (accept_out) begin
            field_r <= {11'd0, field_r[FIELD_BITS-1:CHAN_BITS]};
            idx_r   <= idx_r + 4'd1;
          end
        end
        default: idx_r <= idx_r;
      endcase
    end
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = (state_r == S_EMIT);
  assign out_channel_index = idx_r;
  assign out_channel_value = field_r[CHAN_BITS-1:0];
  assign out_drive_left    = pub_left_r;
  assign out_drive_right   = pub_right_r;
  assign out_failsafe      = pub_fs_r;
  assign out_last          = (idx_r == 4'(CHAN_COUNT - 1));

endmodule

`default_nettype wire

[hdl/sbed_checker.sv]
// Port-level checks of the result run, bound to the top level.
`default_nettype none

module sbed_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [3:0]        out_channel_index,
  input logic [10:0]       out_channel_value,
  input logic signed [8:0] out_drive_left,
  input logic signed [8:0] out_drive_right,
  input logic              out_failsafe,
  input logic              out_last
);

  // No new edge is taken while results are pending
  a_busy_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while a result is pending");

  // A run continues with the next channel until the last one
  a_run_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=>
      (out_valid && (out_channel_index == 4'($past(out_channel_index) + 4'd1))))
    else $error("result run broke off or skipped a channel");

  // A stalled result holds
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_channel_value)))
    else $error("stalled result changed");

  // Drives and failsafe stay fixed through a run
  a_run_shared: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(out_valid)) |->
      ($stable(out_drive_left) && $stable(out_drive_right) && $stable(out_failsafe)))
    else $error("drive or failsafe changed within a run");

endmodule

bind sbus_edge_decoder_mixer sbed_checker u_sbed_checker (.*);

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the edge decoder and mixer: line edges in, channel results checked.
`timescale 1ns / 100ps

module testbench;
  import sbed_pkg::*;

  localparam int STORE_BITS   = 300;
  localparam int DRAIN_CYCLES = 150;
  localparam int CYCLE_LIMIT  = 2_000_000;

  // One channel result as it leaves the block
  typedef struct {
    logic [3:0]        chan;
    logic [10:0]       value;
    logic signed [8:0] left;
    logic signed [8:0] right;
    logic              fs;
    logic              is_last;
  } chan_result_t;

  // Tracks the packet store and published set, and holds the channel results still due
  class drive_set_tracker;
    bit           line_bits[STORE_BITS];
    int unsigned  fill_pos;
    bit [31:0]    last_stamp;
    bit [10:0]    shown_chan[16];
    int           shown_left;
    int           shown_right;
    bit           shown_fs;
    bit [31:0]    gap;
    bit [11:0]    mask;
    chan_result_t due_channels[$];
    int           emitted;
    int           faults;

    function new();
      gap  = 32'd2000;
      mask = 12'd2051;
    endfunction

    function void set_reg(cfg_reg_t idx, bit [31:0] value);
      case (idx)
        REG_GAP:  gap = value;
        REG_MASK: mask = value[11:0];
        default: ;
      endcase
    endfunction

    function int clamp_255(int v);
      if (v > 255) return 255;
      if (v < -255) return -255;
      return v;
    endfunction

    // Map 172..1811 onto -255..255, truncating toward zero
    function int scale_raw(bit [10:0] raw);
      int s;
      s = -255 + ((int'(raw) - 172) * 510) / 1639;
      return clamp_255(s);
    endfunction

    // Note one accepted edge: fill bits, or decode at a packet boundary
    function void take_edge(bit level, bit [31:0] stamp);
      bit [31:0]         elapsed;
      longint unsigned   wide;
      longint unsigned   stop;
      bit [11:0]         frame;
      bit [175:0]        field;
      bit [10:0]         chans[16];
      bit                framed;
      bit                changed;
      bit                fs;
      int                s0;
      int                s1;
      int                left;
      int                right;
      chan_result_t      r;
      elapsed    = stamp - last_stamp;
      last_stamp = stamp;
      if (elapsed < gap) begin
        wide = elapsed;
        stop = fill_pos + (wide + 5) / 10;
        if (stop > STORE_BITS) stop = STORE_BITS;
        for (longint unsigned i = fill_pos; i < stop; i++) line_bits[i] = ~level;
        fill_pos = stop;
        return;
      end
      // Check start and stop bits of every frame under the mask
      framed = 1'b1;
      for (int f = 0; f < 24; f++) begin
        for (int i = 0; i < 12; i++) frame[11-i] = line_bits[f*12+i];
        if ((frame & mask) != 12'h800) framed = 1'b0;
      end
      if (framed) begin
        for (int f = 0; f < 22; f++)
          for (int i = 0; i < 8; i++) field[f*8+i] = ~line_bits[(f+1)*12+1+i];
        for (int c = 0; c < 16; c++)
          for (int i = 0; i < 11; i++) chans[c][i] = field[c*11+i];
        fs    = !(line_bits[279] && line_bits[280]);
        s0    = scale_raw(chans[0]);
        s1    = scale_raw(chans[1]);
        left  = clamp_255(s0 + s1);
        right = clamp_255(s1 - s0);
        changed = (fs != shown_fs) || (left != shown_left) || (right != shown_right);
        for (int c = 0; c < 16; c++) if (chans[c] != shown_chan[c]) changed = 1'b1;
        // Publish and queue all sixteen channels only on a new set
        if (changed) begin
          shown_chan  = chans;
          shown_left  = left;
          shown_right = right;
          shown_fs    = fs;
          for (int c = 0; c < 16; c++) begin
            r.chan    = c;
            r.value   = chans[c];
            r.left    = left[8:0];
            r.right   = right[8:0];
            r.fs      = fs;
            r.is_last = (c == 15);
            due_channels.push_back(r);
          end
          emitted += 16;
        end
      end
      foreach (line_bits[i]) line_bits[i] = 1'b0;
      fill_pos = 0;
    endfunction

    // Compare one result with the oldest channel still due
    function void match_channel(chan_result_t got);
      chan_result_t want;
      if (due_channels.size() == 0) begin
        $error("unexpected result: channel_index %0d channel_value %0d", got.chan, got.value);
        faults++;
        return;
      end
      want = due_channels.pop_front();
      if (got.chan !== want.chan) begin
        $error("channel_index: expected %0d, got %0d", want.chan, got.chan);
        faults++;
      end
      if (got.value !== want.value) begin
        $error("channel_value: expected %0d, got %0d", want.value, got.value);
        faults++;
      end
      if (got.left !== want.left) begin
        $error("drive_left: expected %0d, got %0d", want.left, got.left);
        faults++;
      end
      if (got.right !== want.right) begin
        $error("drive_right: expected %0d, got %0d", want.right, got.right);
        faults++;
      end
      if (got.fs !== want.fs) begin
        $error("failsafe: expected %0d, got %0d", want.fs, got.fs);
        faults++;
      end
      if (got.is_last !== want.is_last) begin
        $error("last: expected %0d, got %0d", want.is_last, got.is_last);
        faults++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_line_level = 1'b0;
  logic [31:0]       in_edge_time = 32'd0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [3:0]        out_channel_index;
  logic [10:0]       out_channel_value;
  logic signed [8:0] out_drive_left;
  logic signed [8:0] out_drive_right;
  logic              out_failsafe;
  logic              out_last;
  logic              cfg_we = 1'b0;
  logic [0:0]        cfg_index = REG_GAP;
  logic [31:0]       cfg_wdata = 32'd0;

  drive_set_tracker tracker;
  bit               rst_done = 1'b0;
  bit               calm = 1'b0;
  bit [31:0]        edge_clock = 32'd0;
  bit               last_pkt[$];
  int               edges_sent = 0;
  int               ready_hold = 0;
  int               cycles = 0;

  sbus_edge_decoder_mixer #(.PACKET_BITS(STORE_BITS)) dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Random idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Raw channel value: corners, the scaled span, or anything
  function automatic bit [10:0] pick_raw();
    bit [10:0] corners[8] = '{11'd0, 11'd171, 11'd172, 11'd173,
                              11'd1810, 11'd1811, 11'd1812, 11'd2047};
    int        r;
    r = $urandom_range(0, 9);
    if (r < 2) return corners[$urandom_range(0, 7)];
    if (r < 6) return 11'($urandom_range(172, 1811));
    return 11'($urandom_range(0, 2047));
  endfunction

  // Lay out 24 frames of store bits carrying the channels; masked bits are forced legal
  function automatic void build_packet(input bit [10:0] ch[16], input bit [1:0] fs_pair,
                                       input bit [11:0] mask, output bit bits[$]);
    bit         b;
    bit [175:0] field;
    bits = {};
    for (int c = 0; c < 16; c++)
      for (int i = 0; i < 11; i++) field[c*11+i] = ch[c][i];
    for (int f = 0; f < 24; f++) begin
      for (int i = 0; i < 12; i++) begin
        b = $urandom_range(0, 1);
        if (i == 0) b = 1'b1;
        else if (i >= 10) b = 1'b0;
        else if (i <= 8 && f >= 1 && f <= 22) b = ~field[(f-1)*8+i-1];
        if (f == 23 && i == 3) b = fs_pair[0];
        if (f == 23 && i == 4) b = fs_pair[1];
        if (mask[11-i]) b = (i == 0);
        bits.push_back(b);
      end
    end
  endfunction

  // Offer one edge and hold it until accepted
  task automatic send_edge(input bit level, input bit [31:0] stamp);
    int pause;
    pause = idle_len();
    if (pause > 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_line_level <= level;
    in_edge_time  <= stamp;
    do @(posedge clk); while (!in_ready);
    tracker.take_edge(level, stamp);
    edge_clock = stamp;
    edges_sent++;
  endtask

  task automatic advance(input bit level, input bit [31:0] elapsed);
    send_edge(level, edge_clock + elapsed);
  endtask

  // End the packet with a silent gap at or just above the boundary
  task automatic close_packet();
    bit [31:0] room;
    room = 32'hFFFF_FFFF - tracker.gap;
    if (room > 300) room = 300;
    advance($urandom_range(0, 1), tracker.gap + $urandom_range(0, room));
  endtask

  // Turn store bits into edges: one edge per run, with jitter inside rounding
  task automatic send_packet(input bit bits[$]);
    int k;
    int run;
    k = 0;
    while (k < bits.size()) begin
      run = 1;
      while (k + run < bits.size() && bits[k+run] == bits[k]) run++;
      if ($urandom_range(0, 19) == 0) advance($urandom_range(0, 1), $urandom_range(0, 4));
      advance(~bits[k], 10 * run - 5 + $urandom_range(0, 9));
      k += run;
    end
    close_packet();
  endtask

  task automatic fixed_packet(input bit [10:0] c0, input bit [10:0] c1,
                              input bit [1:0] fs_pair);
    bit [10:0] ch[16];
    foreach (ch[c]) ch[c] = pick_raw();
    ch[0] = c0;
    ch[1] = c1;
    build_packet(ch, fs_pair, tracker.mask, last_pkt);
    send_packet(last_pkt);
  endtask

  // Mostly good packets, some repeats, damaged, overlong packets and noise
  task automatic random_packet();
    bit [10:0] ch[16];
    bit        pkt[$];
    int        kind;
    kind = $urandom_range(0, 99);
    if (kind < 12 && last_pkt.size() != 0) begin
      send_packet(last_pkt);
      return;
    end
    if (kind < 20) begin
      repeat ($urandom_range(2, 6)) send_edge($urandom_range(0, 1), $urandom);
      close_packet();
      return;
    end
    foreach (ch[c]) ch[c] = pick_raw();
    build_packet(ch, $urandom_range(0, 3), tracker.mask, pkt);
    if (kind < 30) begin
      if ($urandom_range(0, 1)) pkt[$urandom_range(0, 287)] ^= 1'b1;
      else repeat ($urandom_range(1, 60)) void'(pkt.pop_back());
    end else if (kind < 38) begin
      repeat ($urandom_range(1, 40)) pkt.push_back($urandom_range(0, 1));
    end else begin
      last_pkt = pkt;
    end
    send_packet(pkt);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_reg(idx, value);
    @(posedge clk);
  endtask

  // Drop valid, drain all due results, then let a decode with no result finish
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.due_channels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result side: check each accepted item, stall at random
  always @(posedge clk) begin : rx
    chan_result_t seen;
    if (rst_done) begin
      if (out_valid && out_ready) begin
        seen.chan    = out_channel_index;
        seen.value   = out_channel_value;
        seen.left    = out_drive_left;
        seen.right   = out_drive_right;
        seen.fs      = out_failsafe;
        seen.is_last = out_last;
        tracker.match_channel(seen);
      end
      if (ready_hold > 0) begin
        out_ready <= 1'b0;
        ready_hold--;
      end else begin
        out_ready <= 1'b1;
        ready_hold = idle_len();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL sbus_edge_decoder_mixer");
      $finish;
    end
  end

  initial begin
    bit [10:0] ch[16];
    bit        pkt[$];
    bit [31:0] gap_pick;
    bit [11:0] mask_pick;
    int        phase;
    int        edges_at;
    int        results_at;
    tracker = new();
    repeat (12) @(posedge clk);
    rst_n    <= 1'b1;
    rst_done <= 1'b1;
    @(posedge clk);

    // Rounding edges, saturation past the store end, exact boundary, timestamp wrap
    advance(1'b0, 32'd0);
    advance(1'b1, 32'd4);
    advance(1'b0, 32'd5);
    advance(1'b1, 32'd1999);
    advance(1'b0, 32'd1994);
    advance(1'b1, 32'd2000);
    send_edge(1'b0, 32'hFFFF_FFF0);
    send_edge(1'b1, 32'h0000_0010);
    advance(1'b0, 32'hFFFF_FFFF);
    settle();
    write_reg(REG_GAP, 32'hFFFF_FFFF);
    advance(1'b1, 32'hFFFF_FFFE);
    advance(1'b0, 32'hFFFF_FFFF);
    settle();
    write_reg(REG_GAP, 32'd0);
    advance(1'b1, 32'd0);
    advance(1'b0, 32'd7);
    settle();
    write_reg(REG_GAP, 32'd1);
    advance(1'b1, 32'd0);
    advance(1'b0, 32'd1);
    settle();
    write_reg(REG_GAP, 32'd2000);

    // Scaling corners, unchanged set, bad frame, overlong packet
    close_packet();
    fixed_packet(11'd172, 11'd1811, 2'b11);
    send_packet(last_pkt);
    fixed_packet(11'd0, 11'd0, 2'b00);
    fixed_packet(11'd2047, 11'd2047, 2'b01);
    fixed_packet(11'd1811, 11'd172, 2'b10);
    foreach (ch[c]) ch[c] = pick_raw();
    build_packet(ch, 2'b11, tracker.mask, pkt);
    pkt[5*12+11] = 1'b1;
    send_packet(pkt);
    build_packet(ch, 2'b11, tracker.mask, pkt);
    repeat (40) pkt.push_back(1'b1);
    send_packet(pkt);

    // Mask extremes: nothing can pass, and only the start bit alone passes
    settle();
    write_reg(REG_MASK, 32'd0);
    fixed_packet(pick_raw(), pick_raw(), 2'b11);
    settle();
    write_reg(REG_MASK, {20'($urandom), 12'hFFF});
    fixed_packet(pick_raw(), pick_raw(), 2'b00);

    // Random phases, each under its own register setting
    edges_at   = edges_sent;
    results_at = tracker.emitted;
    phase      = 0;
    while ((edges_sent - edges_at < 350 || tracker.emitted - results_at < 64) && phase < 12) begin
      case (phase)
        0: begin
          gap_pick  = 32'd2000;
          mask_pick = 12'd2051;
        end
        1: begin
          gap_pick  = 32'hFFFF_FFFF;
          mask_pick = 12'hFFF;
        end
        2: begin
          gap_pick  = 32'd600;
          mask_pick = 12'h800;
        end
        default: begin
          case ($urandom_range(0, 3))
            0: gap_pick = 32'd2000;
            1: gap_pick = 32'hFFFF_FFFF;
            2: gap_pick = $urandom_range(600, 5000);
            default: gap_pick = $urandom_range(600, 32'h7FFF_FFFF);
          endcase
          case ($urandom_range(0, 9))
            0: mask_pick = 12'd2051;
            1: mask_pick = 12'($urandom);
            2: mask_pick = 12'hFFF;
            default: mask_pick = 12'($urandom) | 12'h800;
          endcase
        end
      endcase
      settle();
      write_reg(REG_GAP, gap_pick);
      write_reg(REG_MASK, {20'($urandom), mask_pick});
      calm = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 4)) random_packet();
      phase++;
    end

    settle();
    if (tracker.due_channels.size() != 0) begin
      $error("%0d channel results never arrived", tracker.due_channels.size());
      tracker.faults++;
    end
    if (tracker.faults == 0) begin
      $display("PASS sbus_edge_decoder_mixer");
    end else begin
      $display("FAIL sbus_edge_decoder_mixer");
    end
    $finish;
  end

endmodule
